/* src/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

/* src/c3s_pkg.sv */
//------------------------------------------------------------------------------
// c3s_pkg
// Shared constants and the data handed between solver cells.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package c3s_pkg;

   // element format, signed Q8.8
   localparam int ElemWidth  = 16;
   localparam int FracBits   = 8;

   // widths of the internal arithmetic
   localparam int DetWidth   = 3*ElemWidth + 3;         // 3x3 determinant
   localparam int NumWidth   = DetWidth + FracBits + 1; // shifted numerator
   localparam int QuoWidth   = NumWidth;                // quotient magnitude
   localparam int ThreshWidth = 48;

   // register indexes
   localparam logic [0:0] RegThreshold = 1'b0;

endpackage

`default_nettype wire

/* src/c3s_div_cell.sv */
//------------------------------------------------------------------------------
// c3s_div_cell
// One restoring-division step for three numerators sharing one divisor.
// Each cell settles one quotient bit and passes the partial remainders on.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c3s_div_cell
   import c3s_pkg::*;
#(
   parameter int BitIdx = 0
) (
   input  wire logic                  clock,
   input  wire logic                  in_valid,
   input  wire logic [DetWidth-1:0]   in_dmag,
   input  wire logic [NumWidth-1:0]   in_rem  [3],
   input  wire logic [QuoWidth-1:0]   in_quo  [3],
   input  wire logic [7:0]            in_tag,
   output logic                       out_valid,
   output logic [DetWidth-1:0]        out_dmag,
   output logic [NumWidth-1:0]        out_rem [3],
   output logic [QuoWidth-1:0]        out_quo [3],
   output logic [7:0]                 out_tag
);

   logic [NumWidth-1:0] rem_in [3];
   logic [QuoWidth-1:0] quo_in [3];
   logic [NumWidth+DetWidth-1:0] shifted;

   // compare remainder with divisor shifted to this bit
   always_comb begin
      shifted = {{NumWidth{1'b0}}, in_dmag} << BitIdx;
      for (int i = 0; i < 3; i++) begin
         rem_in[i] = in_rem[i];
         quo_in[i] = in_quo[i];
         if ({{DetWidth{1'b0}}, in_rem[i]} >= shifted) begin
            rem_in[i] = in_rem[i] - shifted[NumWidth-1:0];
            quo_in[i][BitIdx] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_valid <= in_valid;
      out_dmag  <= in_dmag;
      out_rem   <= rem_in;
      out_quo   <= quo_in;
      out_tag   <= in_tag;
   end

endmodule

`default_nettype wire

/* src/cramer_3x3_solver.sv */
//------------------------------------------------------------------------------
// cramer_3x3_solver
// Cramer's-rule solver for a 3x3 system in signed Q8.8.
//------------------------------------------------------------------------------
// Pulse start with the nine matrix entries and three right-hand values on the
// req_ ports; busy is never high, so a transaction is accepted every cycle.
// One result per transaction appears on the rsp_ ports for one cycle, marked
// by rsp_strobe. The pipeline holds an input register, minor products,
// top-row products, determinant and numerator magnitudes, then 60 division
// cells (one quotient bit each), then one output register.
// Throughput: one transaction per cycle, every stage is fully pipelined.
// The singular threshold lies at CSR address 0 (48 bits in a 64-bit word); the
// user must change it only while no transaction is in flight, unenforced here.
// Reset clears the valid chain and sets the threshold to 1; transactions in
// flight are dropped. The receiver cannot stall, none is needed.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cramer_3x3_solver
   import c3s_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic signed [ElemWidth-1:0]  req_a00, req_a01, req_a02,
   input  wire logic signed [ElemWidth-1:0]  req_a10, req_a11, req_a12,
   input  wire logic signed [ElemWidth-1:0]  req_a20, req_a21, req_a22,
   input  wire logic signed [ElemWidth-1:0]  req_rhs0, req_rhs1, req_rhs2,
   output logic                              rsp_strobe,
   output logic signed [ElemWidth-1:0]       rsp_sol0, rsp_sol1, rsp_sol2,
   output logic                              rsp_singular,
   output logic                              rsp_clipped,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [0:0]                   paddr,
   input  wire logic [63:0]                  pwdata,
   output logic [63:0]                       prdata,
   output logic                              pready
);

   localparam int Steps = QuoWidth;
   localparam int EW = ElemWidth;

   // configuration register
   logic [ThreshWidth-1:0] thresh_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= ThreshWidth'(1);
      end else if (psel && penable && pwrite && paddr == RegThreshold) begin
         thresh_ff <= pwdata[ThreshWidth-1:0];
      end
   end
   assign pready = 1'b1;
   assign prdata = (paddr == RegThreshold) ? {16'd0, thresh_ff} : 64'd0;
   assign busy   = 1'b0;

   // stage 1: input register for the matrix and the right-hand side
   logic signed [EW-1:0] a_ff [3][3];
   logic signed [EW-1:0] b_ff [3];
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   always_ff @(posedge clock) begin
      a_ff[0][0] <= req_a00; a_ff[0][1] <= req_a01; a_ff[0][2] <= req_a02;
      a_ff[1][0] <= req_a10; a_ff[1][1] <= req_a11; a_ff[1][2] <= req_a12;
      a_ff[2][0] <= req_a20; a_ff[2][1] <= req_a21; a_ff[2][2] <= req_a22;
      b_ff[0] <= req_rhs0; b_ff[1] <= req_rhs1; b_ff[2] <= req_rhs2;
   end

   // minor(p,q,r,s) = p*s - q*r, products registered
   logic signed [2*EW-1:0] pa_ff [12], pb_ff [12];
   logic signed [EW-1:0]   top_ff [4][3];
   always_ff @(posedge clock) begin
      // matrix k: column k replaced by b (k=3 means A itself)
      for (int k = 0; k < 4; k++) begin
         logic signed [EW-1:0] m [3][3];
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
               m[r][c] = (c == k) ? b_ff[r] : a_ff[r][c];
         pa_ff[3*k]   <= m[1][1] * m[2][2]; pb_ff[3*k]   <= m[1][2] * m[2][1];
         pa_ff[3*k+1] <= m[1][0] * m[2][2]; pb_ff[3*k+1] <= m[1][2] * m[2][0];
         pa_ff[3*k+2] <= m[1][0] * m[2][1]; pb_ff[3*k+2] <= m[1][1] * m[2][0];
         for (int c = 0; c < 3; c++) top_ff[k][c] <= m[0][c];
      end
   end

   // stage 3: top row times cofactors
   logic signed [2*EW+EW+1:0] t_ff [4][3];
   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++)
         for (int c = 0; c < 3; c++)
            t_ff[k][c] <= top_ff[k][c] *
               ($signed({pa_ff[3*k+c][2*EW-1], pa_ff[3*k+c]}) -
                $signed({pb_ff[3*k+c][2*EW-1], pb_ff[3*k+c]}));
   end

   // stage 4: sum, sign and magnitude, singular test
   logic signed [DetWidth-1:0] det_w [4];
   always_comb begin
      for (int k = 0; k < 4; k++)
         det_w[k] = DetWidth'(t_ff[k][0]) - DetWidth'(t_ff[k][1])
                  + DetWidth'(t_ff[k][2]);
   end

   logic [DetWidth-1:0] dmag_w;
   logic [NumWidth-1:0] nrem_w [3];
   logic [7:0]          tag_w;
   logic                sing_w;
   always_comb begin
      dmag_w = det_w[3][DetWidth-1] ? DetWidth'(-det_w[3]) : det_w[3];
      sing_w = (dmag_w == '0) || (dmag_w < DetWidth'(thresh_ff));
      tag_w  = {4'd0, sing_w, 3'd0};
      for (int i = 0; i < 3; i++) begin
         logic signed [NumWidth-1:0] n;
         n = NumWidth'(det_w[i]) <<< FracBits;
         nrem_w[i] = n[NumWidth-1] ? NumWidth'(-n) : n;
         tag_w[i] = n[NumWidth-1] ^ det_w[3][DetWidth-1];
      end
   end

   // magnitudes registered before the division chain
   logic [DetWidth-1:0] dmag_ff;
   logic [NumWidth-1:0] nrem_ff [3];
   logic [7:0]          tag_ff;
   always_ff @(posedge clock) begin
      dmag_ff <= dmag_w;
      nrem_ff <= nrem_w;
      tag_ff  <= tag_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
      end else begin
         v1_ff <= start; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
      end
   end

   // division chain, most significant quotient bit first
   logic                v_c   [Steps+1];
   logic [DetWidth-1:0] d_c   [Steps+1];
   logic [NumWidth-1:0] r_c   [Steps+1][3];
   logic [QuoWidth-1:0] q_c   [Steps+1][3];
   logic [7:0]          g_c   [Steps+1];

   assign v_c[0] = v4_ff;
   assign d_c[0] = dmag_ff;
   assign r_c[0] = nrem_ff;
   assign q_c[0] = '{default: '0};
   assign g_c[0] = tag_ff;

   for (genvar s = 0; s < Steps; s++) begin : g_cell
      c3s_div_cell #(.BitIdx(Steps-1-s)) u_cell (
         .clock    (clock),
         .in_valid (v_c[s] && !reset),
         .in_dmag  (d_c[s]),
         .in_rem   (r_c[s]),
         .in_quo   (q_c[s]),
         .in_tag   (g_c[s]),
         .out_valid(v_c[s+1]),
         .out_dmag (d_c[s+1]),
         .out_rem  (r_c[s+1]),
         .out_quo  (q_c[s+1]),
         .out_tag  (g_c[s+1])
      );
   end

   // sign, saturation and output register
   logic [EW-1:0] sol_w [3];
   logic          clip_w, sing_o;
   always_comb begin
      sing_o = g_c[Steps][3];
      clip_w = 1'b0;
      for (int i = 0; i < 3; i++) begin
         logic [QuoWidth-1:0] q;
         logic neg;
         q   = q_c[Steps][i];
         neg = g_c[Steps][i] && (q != '0);
         if (!neg) begin
            if (q > QuoWidth'((1 << (EW-1)) - 1)) begin
               q = QuoWidth'((1 << (EW-1)) - 1); clip_w = 1'b1;
            end
            sol_w[i] = q[EW-1:0];
         end else begin
            if (q > QuoWidth'(1 << (EW-1))) begin
               q = QuoWidth'(1 << (EW-1)); clip_w = 1'b1;
            end
            sol_w[i] = EW'(-q);
         end
      end
      if (sing_o) begin
         sol_w = '{default: '0}; clip_w = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_strobe <= 1'b0;
      else       rsp_strobe <= v_c[Steps];
      rsp_sol0 <= sol_w[0]; rsp_sol1 <= sol_w[1]; rsp_sol2 <= sol_w[2];
      rsp_singular <= sing_o; rsp_clipped <= clip_w;
   end

endmodule

`default_nettype wire

/* src/c3s_checker.sv */
//------------------------------------------------------------------------------
// c3s_checker
// Port-level checks on the solver's result channel, busy and pready.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module c3s_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        busy,
   input wire logic        rsp_strobe,
   input wire logic [15:0] rsp_sol0,
   input wire logic [15:0] rsp_sol1,
   input wire logic [15:0] rsp_sol2,
   input wire logic        rsp_singular,
   input wire logic        rsp_clipped,
   input wire logic        pready
);

   `ASSERT_IMPLY(a_sing_zero, clock, reset, rsp_strobe && rsp_singular,
      rsp_sol0 == 16'd0 && rsp_sol1 == 16'd0 && rsp_sol2 == 16'd0 && !rsp_clipped)
   `ASSERT_IMPLY(a_never_busy, clock, reset, 1'b1, !busy && pready)
   `ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_strobe)

endmodule

bind cramer_3x3_solver c3s_checker u_c3s_checker (
   .clock(clock), .reset(reset), .busy(busy), .rsp_strobe(rsp_strobe),
   .rsp_sol0(rsp_sol0), .rsp_sol1(rsp_sol1), .rsp_sol2(rsp_sol2),
   .rsp_singular(rsp_singular), .rsp_clipped(rsp_clipped), .pready(pready)
);

`default_nettype wire

/* sim/testbench.sv */
//------------------------------------------------------------------------------
// testbench
// Self-checking bench for the 3x3 Cramer's-rule solver: directed corner
// systems and random systems are checked against an in-bench predictor
// over several singular-threshold settings and idle patterns.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench
   import c3s_pkg::*;
;

   typedef logic signed [15:0] elem_type;
   typedef elem_type system_type [12];

   typedef struct {
      elem_type sol0;
      elem_type sol1;
      elem_type sol2;
      logic  singular;
      logic  clipped;
   } solution_type;

   localparam longint unsigned ThreshMax = 64'hFFFF_FFFF_FFFF;
   localparam longint ElemMax = 32767;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   elem_type req_a00 = '0, req_a01 = '0, req_a02 = '0;
   elem_type req_a10 = '0, req_a11 = '0, req_a12 = '0;
   elem_type req_a20 = '0, req_a21 = '0, req_a22 = '0;
   elem_type req_rhs0 = '0, req_rhs1 = '0, req_rhs2 = '0;
   logic rsp_strobe;
   elem_type rsp_sol0, rsp_sol1, rsp_sol2;
   logic rsp_singular, rsp_clipped;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [0:0] paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic pready;

   solution_type pending_solutions[$];
   longint unsigned threshold_copy;
   int mismatches = 0;
   int sender_idle_pct = 0;

   cramer_3x3_solver uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_a00(req_a00), .req_a01(req_a01), .req_a02(req_a02),
      .req_a10(req_a10), .req_a11(req_a11), .req_a12(req_a12),
      .req_a20(req_a20), .req_a21(req_a21), .req_a22(req_a22),
      .req_rhs0(req_rhs0), .req_rhs1(req_rhs1), .req_rhs2(req_rhs2),
      .rsp_strobe(rsp_strobe), .rsp_sol0(rsp_sol0), .rsp_sol1(rsp_sol1),
      .rsp_sol2(rsp_sol2), .rsp_singular(rsp_singular), .rsp_clipped(rsp_clipped),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // 3x3 determinant, row-major, exact in 64 bits for 16-bit entries
   function automatic longint det_of(input longint m [9]);
      longint c0, c1, c2;
      c0 = m[4] * m[8] - m[5] * m[7];
      c1 = m[3] * m[8] - m[5] * m[6];
      c2 = m[3] * m[7] - m[4] * m[6];
      return m[0] * c0 - m[1] * c1 + m[2] * c2;
   endfunction

   // expected solution of one system
   function automatic solution_type solve_system(input system_type s);
      solution_type r;
      longint a [9];
      longint m [9];
      longint det, num, q;
      longint unsigned dmag, nmag;
      elem_type x [3];
      bit qneg;
      a = '{default: 0};
      for (int k = 0; k < 9; k++) a[k] = s[k];
      det = det_of(a);
      dmag = (det < 0) ? -det : det;
      r.singular = 1'b0;
      r.clipped = 1'b0;
      if (dmag == 0 || dmag < threshold_copy) begin
         r.sol0 = '0; r.sol1 = '0; r.sol2 = '0;
         r.singular = 1'b1;
         return r;
      end
      for (int i = 0; i < 3; i++) begin
         m = a;
         for (int row = 0; row < 3; row++) m[row*3 + i] = s[9 + row];
         num = det_of(m) <<< 8;
         nmag = (num < 0) ? -num : num;
         q = nmag / dmag;
         qneg = ((num < 0) != (det < 0)) && q != 0;
         if (!qneg && q > ElemMax) begin
            q = ElemMax;
            r.clipped = 1'b1;
         end else if (qneg && q > ElemMax + 1) begin
            q = ElemMax + 1;
            r.clipped = 1'b1;
         end
         x[i] = qneg ? elem_type'(-q) : elem_type'(q);
      end
      r.sol0 = x[0]; r.sol1 = x[1]; r.sol2 = x[2];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // result checker
   always @(posedge clock) begin
      solution_type w;
      if (!reset && rsp_strobe) begin
         if (pending_solutions.size() == 0) begin
            report_mismatch("unexpected transaction", 1, 0);
         end else begin
            w = pending_solutions.pop_front();
            if (rsp_sol0 !== w.sol0) report_mismatch("sol0", rsp_sol0, w.sol0);
            if (rsp_sol1 !== w.sol1) report_mismatch("sol1", rsp_sol1, w.sol1);
            if (rsp_sol2 !== w.sol2) report_mismatch("sol2", rsp_sol2, w.sol2);
            if (rsp_singular !== w.singular)
               report_mismatch("singular", rsp_singular, w.singular);
            if (rsp_clipped !== w.clipped)
               report_mismatch("clipped", rsp_clipped, w.clipped);
         end
      end
   end

   // send one system; start is left high for a back-to-back transaction
   task automatic send_system(input system_type s);
      logic was_busy;
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      forever begin
         @(negedge clock);
         start <= 1'b1;
         {req_a00, req_a01, req_a02} <= {s[0], s[1], s[2]};
         {req_a10, req_a11, req_a12} <= {s[3], s[4], s[5]};
         {req_a20, req_a21, req_a22} <= {s[6], s[7], s[8]};
         {req_rhs0, req_rhs1, req_rhs2} <= {s[9], s[10], s[11]};
         #1 was_busy = busy;
         @(posedge clock);
         if (!was_busy) break;
      end
      pending_solutions.push_back(solve_system(s));
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain;
      @(negedge clock);
      start <= 1'b0;
      while (pending_solutions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register write: setup then access phase, then read back
   task automatic write_threshold(input longint unsigned value);
      logic rdy;
      @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= RegThreshold; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      forever begin
         #1 rdy = pready;
         @(posedge clock);
         if (rdy) break;
         @(negedge clock);
      end
      threshold_copy = value & ThreshMax;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      #1;
      if (prdata !== threshold_copy)
         report_mismatch("threshold readback", prdata, threshold_copy);
   endtask

   function automatic system_type diag_system(input elem_type d, input elem_type r0,
                                              input elem_type r1, input elem_type r2);
      system_type s;
      s = '{default: '0};
      s[0] = d; s[4] = d; s[8] = d;
      s[9] = r0; s[10] = r1; s[11] = r2;
      return s;
   endfunction

   // corner systems at the default, extreme and boundary thresholds
   task automatic test_directed;
      system_type s;
      write_threshold(1);
      send_system(diag_system(16'sd256, 16'sd300, -16'sd300, 16'sd0));
      send_system(diag_system(16'sd256, 16'sh7FFF, 16'sh8000, 16'sd1));
      send_system(diag_system(-16'sd256, 16'sd512, -16'sd1, 16'sd77));
      // determinant of one LSB: the first two elements saturate
      send_system(diag_system(16'sd1, 16'sh7FFF, 16'sh8000, 16'sd5));
      send_system(diag_system(16'sd1, 16'sd0, 16'sd0, 16'sd0));
      send_system(diag_system(16'sd0, 16'sd100, 16'sd1, 16'sd1));
      s = '{default: 16'sh7FFF}; send_system(s);
      s = '{default: 16'sh8000}; send_system(s);
      s = '{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
            16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF};
      send_system(s);
      s = '{16'sh8000, 16'sh7FFF, 16'sd0, 16'sd0, 16'sh8000, 16'sh7FFF,
            16'sh7FFF, 16'sd0, 16'sh8000, 16'sd1, -16'sd1, 16'sd256};
      send_system(s);
      // dependent rows
      s = '{16'sd256, 16'sd512, 16'sd768, 16'sd512, 16'sd1024, 16'sd1536,
            16'sd3, 16'sd9, 16'sd1, 16'sd4, 16'sd5, 16'sd6};
      send_system(s);
      drain();
      // zero determinant still singular with no threshold
      write_threshold(0);
      send_system(diag_system(16'sd0, 16'sd1, 16'sd2, 16'sd3));
      send_system(diag_system(16'sd1, 16'sd1, 16'sd2, 16'sd3));
      send_system(diag_system(16'sd256, -16'sd9, 16'sd2, 16'sd3));
      drain();
      write_threshold(ThreshMax);
      send_system(diag_system(16'sd256, 16'sd1, 16'sd2, 16'sd3));
      s = '{default: 16'sh8000}; send_system(s);
      s = '{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
            16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sd1, 16'sd2, 16'sd3};
      send_system(s);
      drain();
      // exactly at the threshold is not singular, one below is
      write_threshold(64'd16777216);
      send_system(diag_system(16'sd256, 16'sd10, 16'sd20, 16'sd30));
      send_system(diag_system(16'sd255, 16'sd10, 16'sd20, 16'sd30));
      drain();
   endtask

   function automatic elem_type rand_elem(input int style);
      case (style)
         0: return elem_type'($urandom);
         1: return elem_type'($urandom_range(32) - 16);
         2: return elem_type'($urandom_range(1024) - 512);
         default: return ($urandom_range(1)) ? 16'sh7FFF : 16'sh8000;
      endcase
   endfunction

   // random systems, mostly well conditioned, some wild
   task automatic test_random(input int count, input int idle_pct,
                              input longint unsigned thresh);
      system_type s;
      int style;
      write_threshold(thresh);
      sender_idle_pct = idle_pct;
      repeat (count) begin
         style = $urandom_range(9);
         style = (style < 3) ? 0 : (style < 5) ? 1 : (style < 9) ? 2 : 3;
         for (int k = 0; k < 12; k++) s[k] = rand_elem(style);
         // strengthen the diagonal to keep most systems solvable
         if (style == 2 && $urandom_range(1)) begin
            s[0] = s[0] + 16'sd4096; s[4] = s[4] - 16'sd4096; s[8] = s[8] + 16'sd4096;
         end
         // the odd exactly singular system
         if ($urandom_range(19) == 0)
            for (int c = 0; c < 3; c++) s[6 + c] = s[c];
         send_system(s);
      end
      drain();
      sender_idle_pct = 0;
   endtask

   // timeout
   initial begin
      #5_000_000;
      $display("[cramer_3x3_solver] ERROR");
      $finish;
   end

   initial begin
      threshold_copy = 1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(135, 14, 1);
      test_random(135, 75, 0);
      test_random(135, 0, 64'd1 << $urandom_range(40));
      repeat (80) @(posedge clock);
      if (mismatches == 0 && pending_solutions.size() == 0) begin
         $display("[cramer_3x3_solver] OK");
      end else begin
         $display("[cramer_3x3_solver] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* cramer_3x3_solver.f */
+incdir+src
src/c3s_pkg.sv
src/c3s_div_cell.sv
src/cramer_3x3_solver.sv
src/c3s_checker.sv
sim/testbench.sv
